>>> design/lrafg_pkg.sv
// Package for the LED ring arc frame generator.
// Shared widths, register indexes, frame constants and the command type.
// No dependencies.
package lrafg_pkg;

  localparam int LED_COUNT_DEF   = 32;
  localparam int LED_COUNT_MAX   = 32;
  localparam int IDX_W           = $clog2(LED_COUNT_MAX);
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int ANGLE_W    = 9;
  localparam int LEVEL_W    = 8;
  localparam int LPD_W      = 16;
  localparam int PROD_W     = ANGLE_W + LPD_W;
  localparam int Q_FRAC     = 16;
  localparam int SCALED_W   = PROD_W - Q_FRAC;
  localparam int SCALED_MAX = (1 << SCALED_W) - 1;
  localparam int FRAME_W    = 8;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_LEDS_PER_DEGREE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DIM_LEVEL       = 1'd1;

  localparam logic [LPD_W-1:0]   LPD_RESET       = 16'd5825;
  localparam logic [LEVEL_W-1:0] DIM_LEVEL_RESET = 8'd0;

  localparam int LEDS_PER_GROUP = 8;
  localparam int GROUP_BITS     = $clog2(LEDS_PER_GROUP);
  localparam int GROUP_SHIFT    = 5;
  localparam int CHANNEL_SHIFT  = 2;

  localparam logic [FRAME_W-1:0] CHANNEL_MASK = 8'(LEDS_PER_GROUP - 1);
  localparam logic [FRAME_W-1:0] LEVEL_MASK   = 8'hFE;
  localparam logic [FRAME_W-1:0] FRAME_MARK   = 8'h01;

  typedef struct packed {
    logic [IDX_W-1:0]   start;
    logic [IDX_W-1:0]   width;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } cmd_t;

endpackage

>>> design/lrafg_front.sv
// Front end: accepts items, scales angle and spread, classifies against the
// stored arc and pushes arc commands. Depends on lrafg_pkg.
module lrafg_front #(
  parameter int LED_COUNT = lrafg_pkg::LED_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [lrafg_pkg::ANGLE_W-1:0]      angle,
  input  logic [lrafg_pkg::ANGLE_W-1:0]      spread,
  input  logic [lrafg_pkg::LEVEL_W-1:0]      level,
  input  logic [lrafg_pkg::LPD_W-1:0]        leds_per_degree,
  input  logic [lrafg_pkg::LEVEL_W-1:0]      dim_level,
  output logic                               q_push,
  output lrafg_pkg::cmd_t                    q_data,
  input  logic                               q_full
);

  localparam int MOD_STEPS = $clog2((lrafg_pkg::SCALED_MAX / LED_COUNT) + 1);
  localparam int REM_W     = 16;

  typedef enum logic [4:0] {
    F_IDLE  = 5'b00001,
    F_MUL   = 5'b00010,
    F_MOD   = 5'b00100,
    F_CLASS = 5'b01000,
    F_NEW   = 5'b10000
  } fstate_t;

  fstate_t state, state_next;

  logic [lrafg_pkg::ANGLE_W-1:0]  angle_q, spread_q;
  logic [lrafg_pkg::LEVEL_W-1:0]  level_q;
  logic [lrafg_pkg::SCALED_W-1:0] scaled_angle, scaled_spread;
  logic [lrafg_pkg::IDX_W-1:0]    cur_start, cur_width;
  logic [lrafg_pkg::IDX_W-1:0]    prev_start, prev_width;
  logic [lrafg_pkg::LEVEL_W-1:0]  prev_level;
  logic [lrafg_pkg::PROD_W-1:0]   prod_angle, prod_spread;
  logic [REM_W-1:0]               rem;
  logic [lrafg_pkg::IDX_W-1:0]    start_calc, width_calc;
  logic                           arc_moved, level_changed;

  assign full = (state != F_IDLE);

  assign prod_angle  = {{lrafg_pkg::LPD_W{1'b0}}, angle_q} *
                       {{lrafg_pkg::ANGLE_W{1'b0}}, leds_per_degree};
  assign prod_spread = {{lrafg_pkg::LPD_W{1'b0}}, spread_q} *
                       {{lrafg_pkg::ANGLE_W{1'b0}}, leds_per_degree};

  always_comb begin
    rem = REM_W'(scaled_angle);
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (rem >= (REM_W'(LED_COUNT) << k)) begin
        rem = rem - (REM_W'(LED_COUNT) << k);
      end
    end
    start_calc = rem[lrafg_pkg::IDX_W-1:0];
    if (scaled_spread > lrafg_pkg::SCALED_W'(LED_COUNT - 1)) begin
      width_calc = lrafg_pkg::IDX_W'(LED_COUNT - 1);
    end else begin
      width_calc = scaled_spread[lrafg_pkg::IDX_W-1:0];
    end
  end

  assign arc_moved     = (cur_start != prev_start) || (cur_width != prev_width);
  assign level_changed = (level_q != prev_level);

  always_comb begin
    state_next = state;
    q_push     = 1'b0;
    q_data     = '{start: cur_start, width: cur_width, level: level_q, last: 1'b1};
    unique case (state)
      F_IDLE: begin
        if (push) state_next = F_MUL;
      end
      F_MUL: state_next = F_MOD;
      F_MOD: state_next = F_CLASS;
      F_CLASS: begin
        if (arc_moved) begin
          q_data = '{start: prev_start, width: prev_width, level: dim_level, last: 1'b0};
          q_push = !q_full;
          if (!q_full) state_next = F_NEW;
        end else if (level_changed) begin
          q_push = !q_full;
          if (!q_full) state_next = F_IDLE;
        end else begin
          state_next = F_IDLE;
        end
      end
      F_NEW: begin
        q_push = !q_full;
        if (!q_full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      prev_start <= '0;
      prev_width <= '0;
      prev_level <= '0;
    end else begin
      state <= state_next;
      if (q_push && q_data.last) begin
        prev_start <= cur_start;
        prev_width <= cur_width;
        prev_level <= level_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      angle_q  <= angle;
      spread_q <= spread;
      level_q  <= level;
    end
    if (state == F_MUL) begin
      scaled_angle  <= prod_angle[lrafg_pkg::PROD_W-1:lrafg_pkg::Q_FRAC];
      scaled_spread <= prod_spread[lrafg_pkg::PROD_W-1:lrafg_pkg::Q_FRAC];
    end
    if (state == F_MOD) begin
      cur_start <= start_calc;
      cur_width <= width_calc;
    end
  end

`ifndef SYNTHESIS
  a_class_in_ring: assert property (@(posedge clk) disable iff (rst)
    (state == F_CLASS) |->
      (32'(cur_start) < LED_COUNT) && (32'(cur_width) < LED_COUNT))
    else $error("front: start or width outside the ring");
`endif

endmodule

>>> design/lrafg_cmd_queue.sv
// Short command queue between front end and back end.
// Holds cmd_t entries in flops. Depends on lrafg_pkg.
module lrafg_cmd_queue #(
  parameter int DEPTH = lrafg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lrafg_pkg::cmd_t push_data,
  output logic            full,
  input  logic            pop,
  output lrafg_pkg::cmd_t pop_data,
  output logic            empty
);

  localparam int PTR_W = $clog2(DEPTH);

  lrafg_pkg::cmd_t  entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push, do_pop;

  assign full     = (count == (PTR_W + 1)'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue: push while full");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_W + 1)'(DEPTH))
    else $error("queue: count overflow");
`endif

endmodule

>>> design/lrafg_back.sv
// Back end: walks each arc command into the output register, one LED
// frame per cycle unless a frame waits unpopped. Depends on lrafg_pkg.
module lrafg_back #(
  parameter int LED_COUNT = lrafg_pkg::LED_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lrafg_pkg::cmd_t                   q_data,
  input  logic                              q_empty,
  output logic                              q_pop,
  output logic                              empty,
  input  logic                              pop,
  output logic [lrafg_pkg::FRAME_W-1:0]     frame_first,
  output logic [lrafg_pkg::FRAME_W-1:0]     frame_second,
  output logic                              last_frame
);

  logic                          busy;
  logic                          out_valid;
  logic [lrafg_pkg::IDX_W-1:0]   idx, remaining;
  logic [lrafg_pkg::LEVEL_W-1:0] lvl;
  logic                          last_cmd;
  logic                          load_out;
  logic [lrafg_pkg::FRAME_W-1:0] n8;
  logic [lrafg_pkg::FRAME_W-1:0] first_next, second_next;

  assign empty    = !out_valid;
  assign q_pop    = !busy && !q_empty;
  assign load_out = busy && (!out_valid || pop);

  always_comb begin
    n8          = lrafg_pkg::FRAME_W'(idx);
    first_next  = ((n8 >> lrafg_pkg::GROUP_BITS) << lrafg_pkg::GROUP_SHIFT) |
                  ((n8 & lrafg_pkg::CHANNEL_MASK) << lrafg_pkg::CHANNEL_SHIFT) |
                  {6'd0, lvl[0], 1'b0} | lrafg_pkg::FRAME_MARK;
    second_next = lvl & lrafg_pkg::LEVEL_MASK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
      end else if (load_out && (remaining == '0)) begin
        busy <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      idx       <= q_data.start;
      remaining <= q_data.width;
      lvl       <= q_data.level;
      last_cmd  <= q_data.last;
    end else if (load_out) begin
      idx       <= (idx == lrafg_pkg::IDX_W'(LED_COUNT - 1)) ? '0 : idx + 1'b1;
      remaining <= remaining - 1'b1;
    end
    if (load_out) begin
      frame_first  <= first_next;
      frame_second <= second_next;
      last_frame   <= last_cmd && (remaining == '0);
    end
  end

`ifndef SYNTHESIS
  a_idx_in_ring: assert property (@(posedge clk) disable iff (rst)
    busy |-> (32'(idx) < LED_COUNT) && (32'(remaining) < LED_COUNT))
    else $error("back: index or count outside the ring");
`endif

endmodule

>>> design/led_ring_arc_frame_generator_top.sv
// Top level of the LED ring arc frame generator.
// Uses lrafg_pkg, lrafg_front, lrafg_cmd_queue and lrafg_back.
//
// Input queue side: push an (angle, spread, level) item while full is low.
// Result queue side: a frame (frame_first, frame_second, last_frame) waits
// while empty is low and leaves on pop. last_frame marks the final frame
// of one item; an item that changes nothing yields no frames.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, to be
// written only while the block is idle, which the block itself does not
// enforce; cfg_ready is always high. The front end takes each item through
// accept, multiply, reduce modulo LED_COUNT and classify, plus a further
// step to queue the second command when the arc moves; full stays high
// after the accepting beat until the front end is idle again. The back end
// loads a command and then builds its frames in turn, stalling while a
// built frame waits unpopped. Reset empties both queues, zeroes the stored
// arc and level, and restores the configuration defaults. A stalled pop
// holds the output frame; the back end and then the command queue fill and
// push the stall back to full.
module led_ring_arc_frame_generator_top #(
  parameter int LED_COUNT   = lrafg_pkg::LED_COUNT_DEF,
  parameter int QUEUE_DEPTH = lrafg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic [lrafg_pkg::ANGLE_W-1:0]        angle,
  input  logic [lrafg_pkg::ANGLE_W-1:0]        spread,
  input  logic [lrafg_pkg::LEVEL_W-1:0]        level,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [lrafg_pkg::FRAME_W-1:0]        frame_first,
  output logic [lrafg_pkg::FRAME_W-1:0]        frame_second,
  output logic                                 last_frame,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lrafg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lrafg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [lrafg_pkg::LPD_W-1:0]   leds_per_degree;
  logic [lrafg_pkg::LEVEL_W-1:0] dim_level;
  logic                          q_push, q_full, q_pop, q_empty;
  lrafg_pkg::cmd_t               q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      leds_per_degree <= lrafg_pkg::LPD_RESET;
      dim_level       <= lrafg_pkg::DIM_LEVEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lrafg_pkg::REG_LEDS_PER_DEGREE: leds_per_degree <= cfg_data;
        lrafg_pkg::REG_DIM_LEVEL:       dim_level <= cfg_data[lrafg_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  lrafg_front #(
    .LED_COUNT(LED_COUNT)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .angle           (angle),
    .spread          (spread),
    .level           (level),
    .leds_per_degree (leds_per_degree),
    .dim_level       (dim_level),
    .q_push          (q_push),
    .q_data          (q_wdata),
    .q_full          (q_full)
  );

  lrafg_cmd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  lrafg_back #(
    .LED_COUNT(LED_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_data       (q_rdata),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .frame_first  (frame_first),
    .frame_second (frame_second),
    .last_frame   (last_frame)
  );

endmodule

>>> dv/testbench.sv
// Testbench for led_ring_arc_frame_generator_top: directed stimulus table, then random items
// under several register settings, with frames checked in order against a built-in predictor.
// Depends on lrafg_pkg and the RTL of the block only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lrafg_pkg::*;

  localparam int LEDS        = LED_COUNT_DEF;
  localparam int DRAIN_WAIT  = 2 * LEDS + 16;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int RAND_ITEMS  = 63;
  localparam int HOLD_AFTER  = 400;
  localparam int HOLD_LEN    = 600;

  typedef struct packed {
    logic [FRAME_W-1:0] first;
    logic [FRAME_W-1:0] second;
    logic               last;
  } frame_t;

  typedef struct {
    logic [ANGLE_W-1:0] angle;
    logic [ANGLE_W-1:0] spread;
    logic [LEVEL_W-1:0] level;
    bit                 typed;
    int                 n_frames;
    logic [FRAME_W-1:0] first;
    logic [FRAME_W-1:0] second;
  } script_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   push;
  logic                   full;
  logic [ANGLE_W-1:0]     angle;
  logic [ANGLE_W-1:0]     spread;
  logic [LEVEL_W-1:0]     level;
  logic                   empty;
  logic                   pop;
  logic [FRAME_W-1:0]     frame_first;
  logic [FRAME_W-1:0]     frame_second;
  logic                   last_frame;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  frame_t frames_due[$];
  frame_t arc_frames[$];
  int     fails = 0;
  int     frames_seen = 0;
  int     cycles = 0;

  logic [LPD_W-1:0]   scale_lpd;
  logic [LEVEL_W-1:0] dim_lvl;
  logic [7:0]         arc_start;
  logic [7:0]         arc_width;
  logic [7:0]         arc_level;

  script_row_t script [0:13] = '{
    '{9'd0,   9'd0,   8'h00, 1'b1, 0, 8'h00, 8'h00},
    '{9'd0,   9'd0,   8'hFF, 1'b1, 1, 8'h03, 8'hFE},
    '{9'd11,  9'd0,   8'hFF, 1'b1, 0, 8'h00, 8'h00},
    '{9'd0,   9'd0,   8'h80, 1'b1, 1, 8'h01, 8'h80},
    '{9'd359, 9'd0,   8'h55, 1'b0, 0, 8'h00, 8'h00},
    '{9'd359, 9'd359, 8'hAA, 1'b0, 0, 8'h00, 8'h00},
    '{9'd511, 9'd511, 8'hFF, 1'b0, 0, 8'h00, 8'h00},
    '{9'd511, 9'd511, 8'hFF, 1'b1, 0, 8'h00, 8'h00},
    '{9'd511, 9'd511, 8'h00, 1'b0, 0, 8'h00, 8'h00},
    '{9'd100, 9'd40,  8'h01, 1'b0, 0, 8'h00, 8'h00},
    '{9'd12,  9'd12,  8'h7E, 1'b0, 0, 8'h00, 8'h00},
    '{9'd360, 9'd0,   8'hFF, 1'b0, 0, 8'h00, 8'h00},
    '{9'd0,   9'd359, 8'h01, 1'b0, 0, 8'h00, 8'h00},
    '{9'd0,   9'd0,   8'h00, 1'b0, 0, 8'h00, 8'h00}
  };

  led_ring_arc_frame_generator_top #(
    .LED_COUNT(LEDS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .angle(angle),
    .spread(spread),
    .level(level),
    .empty(empty),
    .pop(pop),
    .frame_first(frame_first),
    .frame_second(frame_second),
    .last_frame(last_frame),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void queue_arc(input logic [7:0] from, input logic [7:0] span,
                                    input logic [LEVEL_W-1:0] lvl);
    int     n;
    frame_t f;
    for (int i = 0; i <= int'(span); i++) begin
      n        = (int'(from) + i) % LEDS;
      f.first  = FRAME_W'(((n / LEDS_PER_GROUP) << GROUP_SHIFT) |
                          ((n % LEDS_PER_GROUP) << CHANNEL_SHIFT) |
                          (int'(lvl[0]) << 1)) | FRAME_MARK;
      f.second = lvl & LEVEL_MASK;
      f.last   = 1'b0;
      arc_frames.push_back(f);
    end
  endfunction

  function automatic void predict_arc_frames(input logic [ANGLE_W-1:0] a,
                                             input logic [ANGLE_W-1:0] s,
                                             input logic [LEVEL_W-1:0] lvl);
    logic [PROD_W-1:0] a_prod;
    logic [PROD_W-1:0] s_prod;
    logic [7:0]        new_start;
    logic [7:0]        new_width;
    int                tail;
    arc_frames.delete();
    a_prod    = PROD_W'(a) * PROD_W'(scale_lpd);
    s_prod    = PROD_W'(s) * PROD_W'(scale_lpd);
    new_start = 8'(int'(a_prod >> Q_FRAC) % LEDS);
    new_width = (int'(s_prod >> Q_FRAC) > LEDS - 1) ? 8'(LEDS - 1) : 8'(s_prod >> Q_FRAC);
    if (new_start != arc_start || new_width != arc_width) begin
      queue_arc(arc_start, arc_width, dim_lvl);
      queue_arc(new_start, new_width, lvl);
      arc_start = new_start;
      arc_width = new_width;
      arc_level = lvl;
    end else if (lvl != arc_level) begin
      queue_arc(new_start, new_width, lvl);
      arc_level = lvl;
    end
    tail = arc_frames.size() - 1;
    if (tail >= 0) arc_frames[tail].last = 1'b1;
  endfunction

  task automatic check_frame(input frame_t got);
    frame_t want;
    if (frames_due.size() == 0) begin
      $error("unexpected frame: frame_first %h frame_second %h last_frame %b",
             got.first, got.second, got.last);
      fails++;
    end else begin
      want = frames_due.pop_front();
      if (got.first !== want.first) begin
        $error("frame_first: expected %h, got %h", want.first, got.first);
        fails++;
      end
      if (got.second !== want.second) begin
        $error("frame_second: expected %h, got %h", want.second, got.second);
        fails++;
      end
      if (got.last !== want.last) begin
        $error("last_frame: expected %b, got %b", want.last, got.last);
        fails++;
      end
    end
  endtask

  // call right after a rising edge; returns right after the edge that took the beat
  task automatic offer_item(input logic [ANGLE_W-1:0] a, input logic [ANGLE_W-1:0] s,
                            input logic [LEVEL_W-1:0] lvl);
    push   <= 1'b1;
    angle  <= a;
    spread <= s;
    level  <= lvl;
    do @(negedge clk); while (full);
    @(posedge clk);
  endtask

  task automatic idle_sender(input bit quiet);
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = 0;
    if (!quiet) begin
      if (r >= 90) gap = $urandom_range(20, 60);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    case (idx)
      REG_LEDS_PER_DEGREE: scale_lpd = data;
      REG_DIM_LEVEL:       dim_lvl   = data[LEVEL_W-1:0];
      default: ;
    endcase
  endtask

  // drain all frames, then wait out any item still in flight that yields nothing
  task automatic settle;
    push <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin : receiver
    int   stall_left;
    int   hold_left;
    bit   held;
    int   r;
    logic next_pop;
    stall_left = 0;
    hold_left  = 0;
    held       = 1'b0;
    pop <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(negedge clk);
      if (pop && !empty) begin
        check_frame('{frame_first, frame_second, last_frame});
        frames_seen++;
      end
      if (!held && frames_seen >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_LEN;
      end
      r = $urandom_range(0, 99);
      if (hold_left > 0) begin
        hold_left--;
        next_pop = 1'b0;
      end else if (cycles[9]) begin
        next_pop = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        next_pop = 1'b0;
      end else begin
        next_pop = 1'b1;
        if (r < 3) stall_left = $urandom_range(15, 40);
        else if (r < 20) stall_left = $urandom_range(1, 3);
      end
      @(posedge clk);
      pop <= next_pop;
    end
  end

  initial begin : stimulus
    logic [LPD_W-1:0]   phase_lpd [0:4];
    logic [CFG_DATA_W-1:0] phase_dim [0:4];
    logic [ANGLE_W-1:0] a;
    logic [ANGLE_W-1:0] s;
    logic [LEVEL_W-1:0] lvl;
    frame_t             f;
    int                 r;
    rst       <= 1'b1;
    push      <= 1'b0;
    angle     <= '0;
    spread    <= '0;
    level     <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_LEDS_PER_DEGREE;
    cfg_data  <= '0;
    scale_lpd = LPD_RESET;
    dim_lvl   = DIM_LEVEL_RESET;
    arc_start = '0;
    arc_width = '0;
    arc_level = '0;
    phase_lpd[0] = 16'hFFFF;
    phase_dim[0] = 16'h00FF;
    phase_lpd[1] = 16'h0000;
    phase_dim[1] = 16'h0001;
    phase_lpd[2] = 16'($urandom_range(0, 65535));
    phase_dim[2] = 16'($urandom_range(0, 65535));
    phase_lpd[3] = 16'd2000;
    phase_dim[3] = 16'h0080;
    phase_lpd[4] = 16'($urandom_range(0, 65535));
    phase_dim[4] = 16'($urandom_range(0, 65535));
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      offer_item(script[i].angle, script[i].spread, script[i].level);
      predict_arc_frames(script[i].angle, script[i].spread, script[i].level);
      if (script[i].typed) begin
        if (script[i].n_frames == 1) begin
          f = '{script[i].first, script[i].second, 1'b1};
          frames_due.push_back(f);
        end
      end else begin
        foreach (arc_frames[k]) frames_due.push_back(arc_frames[k]);
      end
      idle_sender(1'b0);
    end

    a   = '0;
    s   = '0;
    lvl = '0;
    for (int p = 0; p < 5; p++) begin
      settle();
      write_reg(REG_LEDS_PER_DEGREE, phase_lpd[p]);
      write_reg(REG_DIM_LEVEL, phase_dim[p]);
      cfg_valid <= 1'b0;
      for (int i = 0; i < RAND_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          // hold the arc and level
        end else if (r < 30) begin
          lvl = LEVEL_W'($urandom_range(0, 255));
        end else if (r < 40) begin
          a   = ANGLE_W'($urandom_range(0, 511));
          s   = ANGLE_W'($urandom_range(0, 511));
          lvl = LEVEL_W'($urandom_range(0, 255));
        end else begin
          a   = ANGLE_W'($urandom_range(0, 359));
          s   = ($urandom_range(0, 4) == 0) ? ANGLE_W'($urandom_range(0, 359))
                                            : ANGLE_W'($urandom_range(0, 60));
          lvl = LEVEL_W'($urandom_range(0, 255));
        end
        offer_item(a, s, lvl);
        predict_arc_frames(a, s, lvl);
        foreach (arc_frames[k]) frames_due.push_back(arc_frames[k]);
        idle_sender(p[0]);
      end
    end

    settle();
    if (fails == 0 && frames_due.size() == 0) begin
      $display("tb: success");
    end else begin
      if (frames_due.size() != 0)
        $error("frames missing at end: %0d", frames_due.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
